FILE: src/i2ccd_pkg.sv
// ----------------------------------------------------------------------------
// i2ccd_pkg
// Shared widths, constants, handshake structs and a helper for the bus clock
// divider search.
// ----------------------------------------------------------------------------
package i2ccd_pkg;

  localparam int CLK_W  = 27;  // source clock and achieved frequency
  localparam int TGT_W  = 26;  // requested frequency
  localparam int BASE_W = 24;  // clk / (4 * period), period >= 2
  localparam int PER_W  = 8;   // period divider
  localparam int CODE_W = 8;   // divider codes on the ports
  localparam int CNT_W  = $clog2(CLK_W + 1);

  localparam logic [PER_W-1:0] PERIOD_FIRST = PER_W'(2);
  localparam logic [PER_W-1:0] PERIOD_LAST  = PER_W'(255);
  localparam logic [CLK_W-1:0] CLK_RESET    = CLK_W'(40000000);
  localparam int               DIVIDER_LIMIT_DEF = 256;

  typedef struct packed {
    logic             start;
    logic [CLK_W-1:0] dividend;
    logic [CLK_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [CLK_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic idle;
    logic done;
  } srch_stat_t;

  typedef struct packed {
    logic [CODE_W-1:0] module_code;
    logic [CODE_W-1:0] period_code;
    logic              exact_match;
    logic [CLK_W-1:0]  achieved_hz;
  } srch_res_t;

  function automatic logic [CLK_W-1:0] abs_diff(input logic [CLK_W-1:0] a,
                                                input logic [CLK_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

FILE: src/i2ccd_div.sv
// ----------------------------------------------------------------------------
// i2ccd_div
// Bit-serial restoring divider: one quotient bit per cycle, shared by all
// divisions of the search.
// ----------------------------------------------------------------------------
module i2ccd_div (
  input  logic                clk,
  input  logic                rst,
  input  i2ccd_pkg::div_req_t req,
  output i2ccd_pkg::div_rsp_t rsp
);
  import i2ccd_pkg::*;

  logic [CLK_W-1:0] rem;
  logic [CLK_W-1:0] quo;
  logic [CLK_W-1:0] divisor;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [CLK_W:0]   shifted;
  logic [CLK_W:0]   trial;

  assign shifted = {rem, quo[CLK_W-1]};
  assign trial   = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem     <= '0;
        quo     <= req.dividend;
        divisor <= req.divisor;
        cnt     <= CNT_W'(CLK_W);
        busy    <= 1'b1;
      end else if (busy) begin
        // sign bit of trial clear: divisor fits, keep the difference
        if (!trial[CLK_W]) begin
          rem <= trial[CLK_W-1:0];
        end else begin
          rem <= shifted[CLK_W-1:0];
        end
        quo <= {quo[CLK_W-2:0], ~trial[CLK_W]};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

FILE: src/i2ccd_search.sv
// ----------------------------------------------------------------------------
// i2ccd_search
// Sequencer that walks the period dividers, drives the serial divider and
// keeps the best divider pair.
// ----------------------------------------------------------------------------
module i2ccd_search #(
  parameter int DIVIDER_LIMIT = i2ccd_pkg::DIVIDER_LIMIT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [i2ccd_pkg::CLK_W-1:0]        clk_hz,
  input  logic                               start,
  input  logic [i2ccd_pkg::TGT_W-1:0]        target,
  input  logic                               take,
  output i2ccd_pkg::srch_stat_t              stat,
  output i2ccd_pkg::srch_res_t               res,
  output i2ccd_pkg::div_req_t                req,
  input  i2ccd_pkg::div_rsp_t                rsp
);
  import i2ccd_pkg::*;

  localparam int MOD_W = $clog2(DIVIDER_LIMIT + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_BASE   = 3'd1;
  localparam logic [2:0] S_MOD    = 3'd2;
  localparam logic [2:0] S_GOT    = 3'd3;
  localparam logic [2:0] S_CHECK  = 3'd4;
  localparam logic [2:0] S_UPDATE = 3'd5;
  localparam logic [2:0] S_NEXT   = 3'd6;
  localparam logic [2:0] S_FINISH = 3'd7;

  logic [2:0]        state;
  logic [TGT_W-1:0]  tgt;
  logic [PER_W-1:0]  per;
  logic [PER_W-1:0]  per_next;
  logic [BASE_W-1:0] base;
  logic [BASE_W-1:0] module_val;
  logic [BASE_W-1:0] got;
  logic [CLK_W-1:0]  err;
  logic [CLK_W-1:0]  min_err;
  logic [MOD_W-1:0]  best_mod;
  logic [PER_W-1:0]  best_per;
  logic [BASE_W-1:0] best_got;
  logic [MOD_W-1:0]  best_mod_dec;

  assign per_next = per + PER_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      req.start <= 1'b0;
    end else begin
      req.start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            tgt      <= target;
            per      <= PERIOD_FIRST;
            best_mod <= MOD_W'(1);
            best_per <= PERIOD_FIRST;
            best_got <= BASE_W'(clk_hz >> 3);
            min_err  <= abs_diff(clk_hz, CLK_W'(target));
            if (target == '0) begin
              state <= S_FINISH;
            end else begin
              req.start    <= 1'b1;
              req.dividend <= clk_hz;
              req.divisor  <= CLK_W'({PERIOD_FIRST, 2'b00});
              state        <= S_BASE;
            end
          end
        end
        S_BASE: begin
          if (rsp.done) begin
            base         <= rsp.quotient[BASE_W-1:0];
            req.start    <= 1'b1;
            req.dividend <= rsp.quotient;
            req.divisor  <= CLK_W'(tgt);
            state        <= S_MOD;
          end
        end
        S_MOD: begin
          if (rsp.done) begin
            if (rsp.quotient > CLK_W'(DIVIDER_LIMIT)) begin
              state <= S_NEXT;
            end else if (rsp.quotient == '0) begin
              state <= S_FINISH;  // module went to zero: no later period helps
            end else begin
              module_val   <= rsp.quotient[BASE_W-1:0];
              req.start    <= 1'b1;
              req.dividend <= CLK_W'(base);
              req.divisor  <= rsp.quotient;
              state        <= S_GOT;
            end
          end
        end
        S_GOT: begin
          if (rsp.done) begin
            got   <= rsp.quotient[BASE_W-1:0];
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (CLK_W'(got) == CLK_W'(tgt)) begin
            best_mod <= module_val[MOD_W-1:0];
            best_per <= per;
            best_got <= got;
            state    <= S_FINISH;
          end else begin
            err   <= abs_diff(CLK_W'(got), CLK_W'(tgt));
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          // strict compare keeps the first pair on ties
          if (err < min_err) begin
            best_mod <= module_val[MOD_W-1:0];
            best_per <= per;
            best_got <= got;
            min_err  <= err;
          end
          state <= S_NEXT;
        end
        S_NEXT: begin
          if (per == PERIOD_LAST) begin
            state <= S_FINISH;
          end else begin
            per          <= per_next;
            req.start    <= 1'b1;
            req.dividend <= clk_hz;
            req.divisor  <= CLK_W'({per_next, 2'b00});
            state        <= S_BASE;
          end
        end
        S_FINISH: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign best_mod_dec = best_mod - MOD_W'(1);

  assign stat.idle = (state == S_IDLE);
  assign stat.done = (state == S_FINISH);

  assign res.module_code = CODE_W'(best_mod_dec);
  assign res.period_code = best_per - PER_W'(1);
  assign res.exact_match = (tgt != '0) && (CLK_W'(best_got) == CLK_W'(tgt));
  assign res.achieved_hz = CLK_W'(best_got);

endmodule

FILE: src/i2c_clock_divider_search.sv
// ----------------------------------------------------------------------------
// i2c_clock_divider_search
// Finds module and period dividers that bring the source clock closest to a
// requested bus frequency.
// ----------------------------------------------------------------------------
// Search: each period tried takes up to three divisions on the one
//   bit-serial divider plus the check, update and next steps; a zero target
//   skips the divisions, and at most all 254 periods are tried.
// Throughput: one word at a time; the next word is taken once the search has
//   handed its result to the output register.
// Reset: sync, active high; clears control state, source clock = 40000000.
module i2c_clock_divider_search #(
  parameter int DIVIDER_LIMIT = i2ccd_pkg::DIVIDER_LIMIT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [i2ccd_pkg::TGT_W-1:0]         target_hz,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [i2ccd_pkg::CODE_W-1:0]        module_code,
  output logic [i2ccd_pkg::CODE_W-1:0]        period_code,
  output logic                                exact_match,
  output logic [i2ccd_pkg::CLK_W-1:0]         achieved_hz,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [i2ccd_pkg::CLK_W-1:0]         source_clock_hz
);
  import i2ccd_pkg::*;

  logic [CLK_W-1:0] clk_hz;
  srch_stat_t       stat;
  srch_res_t        res;
  div_req_t         req;
  div_rsp_t         rsp;
  logic             accept;
  logic             load;

  assign in_stall  = ~stat.idle;
  // no write in the cycle a word may start a search
  assign cfg_ready = stat.idle & ~in_valid;
  assign accept    = in_valid & ~in_stall;
  assign load      = stat.done & (~out_valid | ~out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      clk_hz <= CLK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      clk_hz <= source_clock_hz;
    end
  end

  i2ccd_search #(
    .DIVIDER_LIMIT(DIVIDER_LIMIT)
  ) u_search (
    .clk    (clk),
    .rst    (rst),
    .clk_hz (clk_hz),
    .start  (accept),
    .target (target_hz),
    .take   (load),
    .stat   (stat),
    .res    (res),
    .req    (req),
    .rsp    (rsp)
  );

  i2ccd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // output register frees the search while a word waits downstream
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      module_code <= res.module_code;
      period_code <= res.period_code;
      exact_match <= res.exact_match;
      achieved_hz <= res.achieved_hz;
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("search not busy after accepting a word");

  a_out_after_search: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a finished search");

  a_period_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (period_code != '0) && (period_code != CODE_W'(255)))
    else $error("period code out of range");

endmodule

FILE: tb/i2c_clock_divider_search_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_clock_divider_search_tb
// Self-checking bench for the bus clock divider search. Requested frequencies
// are fed through a bursty driver. The expected divider pair, exact flag and
// achieved frequency for each word are computed by a local search and checked
// against the output words, under several source clock settings.
// ----------------------------------------------------------------------------
module i2c_clock_divider_search_tb;
  import i2ccd_pkg::*;

  logic              clk;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [TGT_W-1:0]  target_hz = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CODE_W-1:0] module_code;
  logic [CODE_W-1:0] period_code;
  logic              exact_match;
  logic [CLK_W-1:0]  achieved_hz;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CLK_W-1:0]  source_clock_hz = CLK_RESET;

  logic [TGT_W-1:0] pending_target_q[$];
  srch_res_t        expected_div_q[$];
  logic [CLK_W-1:0] src_clk_hz = CLK_RESET;
  int               fail_count = 0;

  // sender burst state
  int burst_left = 0;
  int gap_left = 0;

  // receiver stall state
  int        hold_left = 0;
  int        mode_left = 0;
  int        stall_mode = 0;
  int        result_count = 0;
  srch_res_t got_word;

  i2c_clock_divider_search u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .target_hz      (target_hz),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .module_code    (module_code),
    .period_code    (period_code),
    .exact_match    (exact_match),
    .achieved_hz    (achieved_hz),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .source_clock_hz(source_clock_hz)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Search periods 2..255 in order; exact hit or zero module stops, else first least error.
  function automatic srch_res_t predict_dividers(input logic [TGT_W-1:0] tgt,
                                                 input logic [CLK_W-1:0] src);
    srch_res_t   res;
    int unsigned s, t, per, base, mod_div, got, err, min_err;
    int unsigned best_mod, best_per, ach;
    bit          searching;
    s = src;
    t = tgt;
    best_mod = 1;
    best_per = 2;
    min_err = (s >= t) ? s - t : t - s;
    searching = (t != 0);
    per = 2;
    while (searching && per < 256) begin
      base = s / (4 * per);
      mod_div = base / t;
      if (mod_div == 0) begin
        searching = 1'b0;
      end else if (mod_div <= DIVIDER_LIMIT_DEF) begin
        got = base / mod_div;
        err = (got >= t) ? got - t : t - got;
        if (got == t) begin
          best_mod = mod_div;
          best_per = per;
          searching = 1'b0;
        end else if (err < min_err) begin
          best_mod = mod_div;
          best_per = per;
          min_err = err;
        end
      end
      per++;
    end
    ach = (s / (4 * best_per)) / best_mod;
    res.module_code = CODE_W'(best_mod - 1);
    res.period_code = CODE_W'(best_per - 1);
    res.exact_match = (t != 0) && (ach == t);
    res.achieved_hz = CLK_W'(ach);
    return res;
  endfunction

  // Mostly short searches; a few slow ones that walk all periods.
  function automatic logic [TGT_W-1:0] random_target(input logic [CLK_W-1:0] src);
    int unsigned s, sel, p, m, t;
    s = src;
    sel = $urandom_range(0, 99);
    if (sel < 35) begin
      // built from a divider pair, so an exact hit is likely
      p = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 255) : $urandom_range(2, 16);
      m = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 256);
      t = (s / (4 * p)) / m;
      if (t == 0) t = 1;
    end else if (sel < 75) begin
      t = $urandom_range(s / 256 + 1, s / 4 + 1);
    end else if (sel < 85) begin
      t = $urandom_range(1, s / 256 + 1);
    end else begin
      t = $urandom;
    end
    return TGT_W'(t);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall)
        expected_div_q.push_back(predict_dividers(target_hz, src_clk_hz));
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_target_q.size() != 0) begin
          in_valid <= 1'b1;
          target_hz <= pending_target_q.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
          end else begin
            burst_left = burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
      mode_left = 0;
      stall_mode = 0;
      result_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_div_q.size() == 0) begin
          $error("result word with nothing expected: module_code %0d period_code %0d",
                 module_code, period_code);
          fail_count++;
        end else begin
          got_word = expected_div_q.pop_front();
          if (module_code !== got_word.module_code) begin
            $error("module_code: expected %0d, actual %0d", got_word.module_code,
                   module_code);
            fail_count++;
          end
          if (period_code !== got_word.period_code) begin
            $error("period_code: expected %0d, actual %0d", got_word.period_code,
                   period_code);
            fail_count++;
          end
          if (exact_match !== got_word.exact_match) begin
            $error("exact_match: expected %0b, actual %0b", got_word.exact_match,
                   exact_match);
            fail_count++;
          end
          if (achieved_hz !== got_word.achieved_hz) begin
            $error("achieved_hz: expected %0d, actual %0d", got_word.achieved_hz,
                   achieved_hz);
            fail_count++;
          end
        end
        result_count++;
        // long hold-off so the block backs up into its input
        if (result_count == 12 || result_count == 75) hold_left = 3000;
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 2);
          mode_left = $urandom_range(16, 128);
        end else begin
          mode_left = mode_left - 1;
        end
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task automatic set_source_clock(input logic [CLK_W-1:0] hz);
    @(posedge clk);
    cfg_valid <= 1'b1;
    source_clock_hz <= hz;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    src_clk_hz = hz;
    cfg_valid <= 1'b0;
  endtask

  // sampled on the falling edge so queue and valid updates have settled
  task automatic wait_drained();
    @(negedge clk);
    while (pending_target_q.size() != 0 || in_valid || expected_div_q.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_random(input int n);
    repeat (n) pending_target_q.push_back(random_target(src_clk_hz));
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset clock setting; zero target, nothing-qualifies, exact and nearest
    pending_target_q.push_back('0);
    pending_target_q.push_back(TGT_W'(1));
    pending_target_q.push_back(TGT_W'(100000));
    pending_target_q.push_back(TGT_W'(400000));
    pending_target_q.push_back(TGT_W'(333333));
    pending_target_q.push_back(TGT_W'(1000000));
    pending_target_q.push_back(TGT_W'(5000000));
    pending_target_q.push_back(TGT_W'(40000000));
    pending_target_q.push_back(TGT_W'(33554432));
    pending_target_q.push_back('1);
    run_random(20);

    set_source_clock(CLK_W'(1000000));
    pending_target_q.push_back(TGT_W'(125000));
    pending_target_q.push_back(TGT_W'(1000));
    run_random(20);

    set_source_clock(CLK_W'(100000000));
    pending_target_q.push_back(TGT_W'(100000));
    pending_target_q.push_back(TGT_W'(12500000));
    run_random(20);

    // zero source clock: search ends at the first period
    set_source_clock('0);
    pending_target_q.push_back('0);
    pending_target_q.push_back(TGT_W'(1));
    pending_target_q.push_back(TGT_W'(100000));
    run_random(5);

    set_source_clock('1);
    pending_target_q.push_back(TGT_W'(1));
    pending_target_q.push_back(TGT_W'(1000));
    run_random(15);

    set_source_clock(CLK_W'($urandom_range(1000000, 100000000)));
    run_random(20);

    repeat (200) @(posedge clk);
    if (expected_div_q.size() != 0) begin
      $error("%0d expected result words never arrived", expected_div_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
